### rtl/bqc_pkg.sv
// Shared types, constants and helpers for the band-pass biquad cascade.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bqc_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_STAGES_DEF     = 4;
    localparam int COEF_FRAC_BITS_DEF = 30;
    localparam int GUARD_BITS_DEF     = 8;

    // Fixed widths of the ports and of the stage signals.
    localparam int SAMPLE_W   = 16;
    localparam int SIG_W      = 32;
    localparam int COEF_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HP_GAIN     = 3'd0,
        CFG_HP_POLE_ONE = 3'd1,
        CFG_HP_POLE_TWO = 3'd2,
        CFG_LP_GAIN     = 3'd3,
        CFG_LP_POLE_ONE = 3'd4,
        CFG_LP_POLE_TWO = 3'd5,
        CFG_BYPASS      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [COEF_W-1:0] hp_gain;
        logic [COEF_W-1:0] hp_pole_one;
        logic [COEF_W-1:0] hp_pole_two;
        logic [COEF_W-1:0] lp_gain;
        logic [COEF_W-1:0] lp_pole_one;
        logic [COEF_W-1:0] lp_pole_two;
    } t_coefs;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } t_state;

    // Eight micro-steps per biquad stage. Each step may start one product on
    // the shared multiplier and fold the previous product into the accumulator.
    typedef enum logic [2:0] {
        STP_MUL_A1,   // acc <= x,            prod <= a1*z1
        STP_SUB_A1,   // acc -= rnd(prod),    prod <= a2*z2
        STP_SUB_A2,   // acc -= rnd(prod)
        STP_SAT_W,    // w <= sat(acc),       prod <= b0*z1
        STP_B1,       // acc <= -/+2*rnd,     prod <= b0*z2
        STP_ADD_B2,   // acc += rnd(prod),    prod <= b0*w
        STP_ADD_B0,   // acc += rnd(prod)
        STP_SAT_Y     // x <= sat(acc), rotate delay line
    } t_step;

    typedef struct packed {
        logic  load;
        logic  run;
        t_step step;
        logic  hp;
        logic  out_load;
    } t_dp_cmd;

    function automatic t_step next_step(input t_step s);
        t_step n;
        unique case (s)
            STP_MUL_A1: n = STP_SUB_A1;
            STP_SUB_A1: n = STP_SUB_A2;
            STP_SUB_A2: n = STP_SAT_W;
            STP_SAT_W:  n = STP_B1;
            STP_B1:     n = STP_ADD_B2;
            STP_ADD_B2: n = STP_ADD_B0;
            STP_ADD_B0: n = STP_SAT_Y;
            default:    n = STP_MUL_A1;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

### rtl/bqc_cfg_regs.sv
// Configuration register file: coefficients and the bypass bit.
// Depends on bqc_pkg for the register index codes and the coefficient struct.
`timescale 1ns / 1ps
`default_nettype none

module bqc_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [bqc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bqc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output bqc_pkg::t_coefs            o_coefs,
    output logic                       o_bypass
);
    import bqc_pkg::*;

    t_coefs r_coefs;
    logic   r_bypass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs  <= '0;
            r_bypass <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_HP_GAIN:     r_coefs.hp_gain     <= i_cfg_data[COEF_W-1:0];
                CFG_HP_POLE_ONE: r_coefs.hp_pole_one <= i_cfg_data[COEF_W-1:0];
                CFG_HP_POLE_TWO: r_coefs.hp_pole_two <= i_cfg_data[COEF_W-1:0];
                CFG_LP_GAIN:     r_coefs.lp_gain     <= i_cfg_data[COEF_W-1:0];
                CFG_LP_POLE_ONE: r_coefs.lp_pole_one <= i_cfg_data[COEF_W-1:0];
                CFG_LP_POLE_TWO: r_coefs.lp_pole_two <= i_cfg_data[COEF_W-1:0];
                CFG_BYPASS:      r_bypass            <= i_cfg_data[0];
                default: begin
                    // Unused index: the write is dropped.
                end
            endcase
        end
    end

    assign o_coefs  = r_coefs;
    assign o_bypass = r_bypass;

endmodule

`default_nettype wire

### rtl/bqc_datapath.sv
// Datapath: shared 32x32 multiplier, rounding accumulator, saturation,
// rotating delay line and output register. Depends on bqc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bqc_datapath #(
    parameter int NUM_STAGES     = bqc_pkg::NUM_STAGES_DEF,
    parameter int COEF_FRAC_BITS = bqc_pkg::COEF_FRAC_BITS_DEF,
    parameter int GUARD_BITS     = bqc_pkg::GUARD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bqc_pkg::t_dp_cmd                    i_cmd,
    input  bqc_pkg::t_coefs                     i_coefs,
    input  logic signed [bqc_pkg::SAMPLE_W-1:0] i_sample,
    output logic signed [bqc_pkg::SAMPLE_W-1:0] o_out_sample,
    output logic                                o_clipped
);
    import bqc_pkg::*;

    localparam int PROD_W = SIG_W + COEF_W;
    // A rounded product is at most 2^(62-COEF_FRAC_BITS) in magnitude.
    localparam int RND_W  = PROD_W - COEF_FRAC_BITS;
    localparam int ACC_W  = RND_W + 3;
    localparam int OUT_W  = SIG_W + 1;
    localparam logic signed [PROD_W-1:0] P_HALF = PROD_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [OUT_W-1:0]  O_HALF = (OUT_W'(1) <<< GUARD_BITS) >>> 1;
    localparam logic signed [SIG_W-1:0]  SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
    localparam logic signed [SIG_W-1:0]  SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic signed [SIG_W-1:0]  r_z1 [NUM_STAGES];
    logic signed [SIG_W-1:0]  r_z2 [NUM_STAGES];
    logic signed [SIG_W-1:0]  r_x;
    logic signed [SIG_W-1:0]  r_w;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_clip;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                     r_out_clip;

    logic signed [COEF_W-1:0] b0, a1, a2, mul_a;
    logic signed [SIG_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic                     mul_en;
    logic signed [PROD_W-1:0] prod_shift;
    logic signed [ACC_W-1:0]  prod_rnd;
    logic signed [ACC_W-1:0]  prod_dbl;
    logic signed [SIG_W-1:0]  acc_sat;
    logic                     acc_clip;
    logic signed [OUT_W-1:0]  out_sum;
    logic signed [OUT_W-1:0]  out_shift;
    logic signed [SAMPLE_W-1:0] out_sat;
    logic                     out_clip;

    assign b0 = i_cmd.hp ? signed'(i_coefs.hp_gain)     : signed'(i_coefs.lp_gain);
    assign a1 = i_cmd.hp ? signed'(i_coefs.hp_pole_one) : signed'(i_coefs.lp_pole_one);
    assign a2 = i_cmd.hp ? signed'(i_coefs.hp_pole_two) : signed'(i_coefs.lp_pole_two);

    // The current stage always sits at the head of the delay line.
    always_comb begin
        mul_a  = b0;
        mul_b  = r_w;
        mul_en = i_cmd.run;
        unique case (i_cmd.step)
            STP_MUL_A1: begin mul_a = a1; mul_b = r_z1[0]; end
            STP_SUB_A1: begin mul_a = a2; mul_b = r_z2[0]; end
            STP_SAT_W:  begin mul_a = b0; mul_b = r_z1[0]; end
            STP_B1:     begin mul_a = b0; mul_b = r_z2[0]; end
            STP_ADD_B2: begin mul_a = b0; mul_b = r_w;     end
            default:    mul_en = 1'b0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Round half up, then floor shift back to signal scale.
    assign prod_shift = (r_prod + P_HALF) >>> COEF_FRAC_BITS;
    assign prod_rnd   = prod_shift[ACC_W-1:0];
    assign prod_dbl   = prod_rnd <<< 1;

    always_comb begin
        acc_clip = (r_acc[ACC_W-1:SIG_W-1] != '0) && (r_acc[ACC_W-1:SIG_W-1] != '1);
        if (!acc_clip) begin
            acc_sat = r_acc[SIG_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            acc_sat = SIG_MIN;
        end else begin
            acc_sat = SIG_MAX;
        end
    end

    assign out_sum   = OUT_W'(r_x) + O_HALF;
    assign out_shift = out_sum >>> GUARD_BITS;

    always_comb begin
        out_clip = (out_shift[OUT_W-1:SAMPLE_W-1] != '0) &&
                   (out_shift[OUT_W-1:SAMPLE_W-1] != '1);
        if (!out_clip) begin
            out_sat = out_shift[SAMPLE_W-1:0];
        end else if (out_shift[OUT_W-1]) begin
            out_sat = SMP_MIN;
        end else begin
            out_sat = SMP_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.load) begin
            r_x <= SIG_W'(i_sample) <<< GUARD_BITS;
        end else if (i_cmd.run) begin
            unique case (i_cmd.step)
                STP_MUL_A1: r_acc <= ACC_W'(r_x);
                STP_SUB_A1: r_acc <= r_acc - prod_rnd;
                STP_SUB_A2: r_acc <= r_acc - prod_rnd;
                STP_SAT_W:  r_w   <= acc_sat;
                STP_B1:     r_acc <= i_cmd.hp ? -prod_dbl : prod_dbl;
                STP_ADD_B2: r_acc <= r_acc + prod_rnd;
                STP_ADD_B0: r_acc <= r_acc + prod_rnd;
                STP_SAT_Y:  r_x   <= acc_sat;
                default: begin
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_sample <= out_sat;
            r_out_clip   <= r_clip | out_clip;
        end
    end

    // Clip flag and filter state are control state and are cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= 1'b0;
            for (int i = 0; i < NUM_STAGES; i++) begin
                r_z1[i] <= '0;
                r_z2[i] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_clip <= 1'b0;
            end else if (i_cmd.run && (i_cmd.step == STP_SAT_W ||
                                       i_cmd.step == STP_SAT_Y) && acc_clip) begin
                r_clip <= 1'b1;
            end
            // After each stage the line rotates by one stage, so a full
            // sample leaves every stage back at its own slot.
            if (i_cmd.run && i_cmd.step == STP_SAT_Y) begin
                for (int i = 0; i < NUM_STAGES - 1; i++) begin
                    r_z1[i] <= r_z1[i+1];
                    r_z2[i] <= r_z2[i+1];
                end
                r_z1[NUM_STAGES-1] <= r_w;
                r_z2[NUM_STAGES-1] <= r_z1[0];
            end
        end
    end

    assign o_out_sample = r_out_sample;
    assign o_clipped    = r_out_clip;

endmodule

`default_nettype wire

### rtl/bqc_ctrl.sv
// Controller: sequences the eight micro-steps of every stage, owns the
// input and output handshakes. Depends on bqc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bqc_ctrl #(
    parameter int NUM_STAGES = bqc_pkg::NUM_STAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic              i_bypass,
    output bqc_pkg::t_dp_cmd  o_cmd
);
    import bqc_pkg::*;

    localparam int STG_W = $clog2(NUM_STAGES);

    t_state           r_state, n_state;
    t_step            r_step, n_step;
    logic [STG_W-1:0] r_stage, n_stage;
    logic             r_out_valid, n_out_valid;
    t_dp_cmd          cmd;
    logic             last_stage;

    assign last_stage = (r_stage == STG_W'(NUM_STAGES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STP_MUL_A1;
            r_stage     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_stage     <= n_stage;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_stage     = r_stage;
        n_out_valid = r_out_valid;
        cmd         = '0;
        cmd.step    = r_step;
        cmd.hp      = (r_stage < STG_W'(NUM_STAGES / 2));
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_stage  = '0;
                    n_step   = STP_MUL_A1;
                    // In bypass the rounded output of the loaded sample is the
                    // sample itself, so the stages are skipped.
                    n_state  = i_bypass ? ST_OUT : ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.run = 1'b1;
                n_step  = next_step(r_step);
                if (r_step == STP_SAT_Y) begin
                    if (last_stage) begin
                        n_state = ST_OUT;
                    end else begin
                        n_stage = r_stage + 1'b1;
                    end
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before it was taken");

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_bypass) |=>
            (r_state == ST_RUN && r_step == STP_MUL_A1 && r_stage == '0))
        else $error("filter run did not start at the first stage");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_step != STP_SAT_Y) |=> $stable(r_stage))
        else $error("stage counter moved in the middle of a stage");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_step == STP_SAT_Y && last_stage) |=> (r_state == ST_OUT))
        else $error("last stage did not hand over to the output");
`endif

endmodule

`default_nettype wire

### rtl/biquad_bandpass_cascade.sv
// Top level of the band-pass biquad cascade: configuration registers,
// controller and datapath. Depends on bqc_pkg, bqc_cfg_regs, bqc_ctrl, bqc_datapath.
//
//   Channel   Direction  Handshake                    Payload
//   input     in         i_in_valid / o_in_ready      i_in_sample
//   result    out        o_out_valid / i_out_ready    o_out_sample, o_clipped
//   config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A filtered sample runs through the stages in turn, and no new input is taken until
// it reaches the output register: one shared 32x32 multiplier does five products per
// stage over eight micro-steps. A bypassed sample skips the stages.
// Reset is synchronous and clears the coefficients, bypass and the delay line.
// A result waits in the output register; a following sample is processed
// meanwhile and holds in the controller only if the register is still full.
`timescale 1ns / 1ps
`default_nettype none

module biquad_bandpass_cascade #(
    parameter int NUM_STAGES     = bqc_pkg::NUM_STAGES_DEF,
    parameter int COEF_FRAC_BITS = bqc_pkg::COEF_FRAC_BITS_DEF,
    parameter int GUARD_BITS     = bqc_pkg::GUARD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [bqc_pkg::SAMPLE_W-1:0]   i_in_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [bqc_pkg::SAMPLE_W-1:0]   o_out_sample,
    output logic                                  o_clipped,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [bqc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [bqc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import bqc_pkg::*;

    t_coefs  coefs;
    logic    bypass;
    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    bqc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coefs     (coefs),
        .o_bypass    (bypass)
    );

    bqc_ctrl #(
        .NUM_STAGES (NUM_STAGES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_bypass    (bypass),
        .o_cmd       (cmd)
    );

    bqc_datapath #(
        .NUM_STAGES     (NUM_STAGES),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .GUARD_BITS     (GUARD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_coefs      (coefs),
        .i_sample     (i_in_sample),
        .o_out_sample (o_out_sample),
        .o_clipped    (o_clipped)
    );

endmodule

`default_nettype wire

### bench/bqc_band_checker.sv
`timescale 1ns / 1ps
// Checker for the band-pass biquad cascade: watches the sample, result and register
// channels, predicts every filtered sample and compares it. Depends on bqc_pkg.
module bqc_band_checker #(
    parameter int NUM_STAGES     = bqc_pkg::NUM_STAGES_DEF,
    parameter int COEF_FRAC_BITS = bqc_pkg::COEF_FRAC_BITS_DEF,
    parameter int GUARD_BITS     = bqc_pkg::GUARD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic signed [bqc_pkg::SAMPLE_W-1:0] i_in_sample,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [bqc_pkg::SAMPLE_W-1:0] i_out_sample,
    input  logic                                i_clipped,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [bqc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bqc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                  o_mismatches
);
    import bqc_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } t_filtered;

    localparam longint SIG_HI      = 64'sd2147483647;
    localparam longint SIG_LO      = -64'sd2147483648;
    localparam longint OUT_HI      = 64'sd32767;
    localparam longint OUT_LO      = -64'sd32768;

    logic signed [COEF_W-1:0] hp_b0, hp_a1, hp_a2;
    logic signed [COEF_W-1:0] lp_b0, lp_a1, lp_a2;
    logic                     bypass_on;
    // Stage s keeps z1 at 2s and z2 at 2s+1, always within the 32-bit signal range.
    longint                   delay_line [2*NUM_STAGES];
    t_filtered                predicted_samples [$];

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Exact product, then round half up back to signal scale.
    function automatic longint coef_mul(input longint c, input longint s);
        return (c * s + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    endfunction

    task automatic cascade_sample(input logic signed [SAMPLE_W-1:0] smp,
                                  output t_filtered res);
        longint x, w, y, z1, z2, p0, p1, p2, o;
        longint b0, a1, a2;
        logic   hp, clip;
        int     s;
        if (bypass_on) begin
            res.sample  = smp;
            res.clipped = 1'b0;
            return;
        end
        clip = 1'b0;
        x = longint'(smp) <<< GUARD_BITS;
        for (s = 0; s < NUM_STAGES; s++) begin
            hp = (s < NUM_STAGES / 2);
            b0 = hp ? hp_b0 : lp_b0;
            a1 = hp ? hp_a1 : lp_a1;
            a2 = hp ? hp_a2 : lp_a2;
            z1 = delay_line[2*s];
            z2 = delay_line[2*s+1];
            w = x - coef_mul(a1, z1) - coef_mul(a2, z2);
            if (w > SIG_HI || w < SIG_LO) clip = 1'b1;
            w = clamp_to(w, SIG_LO, SIG_HI);
            p0 = coef_mul(b0, w);
            p1 = coef_mul(b0, z1);
            p2 = coef_mul(b0, z2);
            y = hp ? (p0 - 2 * p1 + p2) : (p0 + 2 * p1 + p2);
            if (y > SIG_HI || y < SIG_LO) clip = 1'b1;
            y = clamp_to(y, SIG_LO, SIG_HI);
            delay_line[2*s+1] = z1;
            delay_line[2*s]   = w;
            x = y;
        end
        o = (GUARD_BITS == 0) ? x
                              : ((x + (longint'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS);
        if (o > OUT_HI || o < OUT_LO) clip = 1'b1;
        o = clamp_to(o, OUT_LO, OUT_HI);
        res.sample  = o[SAMPLE_W-1:0];
        res.clipped = clip;
    endtask

    always @(posedge i_clk) begin : watch
        t_filtered want, got;
        if (!i_rst_n) begin
            hp_b0 = '0; hp_a1 = '0; hp_a2 = '0;
            lp_b0 = '0; lp_a1 = '0; lp_a2 = '0;
            bypass_on = 1'b0;
            foreach (delay_line[i]) delay_line[i] = 0;
            predicted_samples.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HP_GAIN:     hp_b0 = i_cfg_data;
                    CFG_HP_POLE_ONE: hp_a1 = i_cfg_data;
                    CFG_HP_POLE_TWO: hp_a2 = i_cfg_data;
                    CFG_LP_GAIN:     lp_b0 = i_cfg_data;
                    CFG_LP_POLE_ONE: lp_a1 = i_cfg_data;
                    CFG_LP_POLE_TWO: lp_a2 = i_cfg_data;
                    CFG_BYPASS:      bypass_on = i_cfg_data[0];
                    default: ;
                endcase
            end
            // The result side goes first: a result always belongs to an older request.
            if (i_out_valid && i_out_ready) begin
                got.sample  = i_out_sample;
                got.clipped = i_clipped;
                if (predicted_samples.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: expected no result, got out_sample %0d", $time,
                             $signed(got.sample));
                end else begin
                    want = predicted_samples.pop_front();
                    if (want.sample !== got.sample) begin
                        o_mismatches++;
                        $display("%0t: out_sample expected %0d, got %0d", $time,
                                 $signed(want.sample), $signed(got.sample));
                    end
                    if (want.clipped !== got.clipped) begin
                        o_mismatches++;
                        $display("%0t: clipped expected %0b, got %0b", $time,
                                 want.clipped, got.clipped);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                cascade_sample(i_in_sample, want);
                predicted_samples.push_back(want);
            end
        end
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Top of the bench for the band-pass biquad cascade: clock, reset, register setup and
// sample traffic. Depends on bqc_pkg, biquad_bandpass_cascade and bqc_band_checker.
module tb;
    import bqc_pkg::*;

    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  HOLD_CYCLES   = 300;
    localparam int  DRAIN_PAUSE   = 40;
    localparam int  IDLE_PCT      = 27;
    localparam int  PHASE_ITEMS   = 230;
    localparam int  BYPASS_ITEMS  = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam real TWO_PI        = 6.283185307179586;
    localparam real BUTTERWORTH_Q = 0.707;

    typedef enum int {
        WAVE_TONE,
        WAVE_NOISY_TONE,
        WAVE_NOISE,
        WAVE_QUIET,
        WAVE_SQUARE
    } t_wave;

    typedef enum int {
        SET_BAND_LOW,
        SET_BAND_WIDE,
        SET_BAND_NARROW,
        SET_ALL_MAX,
        SET_ALL_MIN,
        SET_RANDOM,
        SET_BYPASS,
        SET_BAND_RANDOM
    } t_setting;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_ready;
    logic signed [SAMPLE_W-1:0]   i_in_sample = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0]   o_out_sample;
    logic                         o_clipped;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data  = '0;

    int mismatches;
    int items_sent   = 0;
    int results_seen = 0;
    int holds_asked  = 0;
    int holds_served = 0;
    int cycle_count  = 0;
    bit gaps_on      = 1'b1;

    logic signed [SAMPLE_W-1:0] corner_vals [5] = '{16'sh7FFF, 16'sh8000, 16'sh0000,
                                                   16'shFFFF, 16'sh0001};

    biquad_bandpass_cascade uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_sample  (i_in_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_sample (o_out_sample),
        .o_clipped    (o_clipped),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    bqc_band_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_sample  (i_in_sample),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_sample (o_out_sample),
        .i_clipped    (o_clipped),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) results_seen <= results_seen + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb failed");
        $finish;
    end

    // Result side: random back-pressure, plus a long hold-off whenever one is asked for.
    initial begin
        forever begin
            @(posedge i_clk);
            if (holds_served < holds_asked) begin
                holds_served++;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_in_sample <= v;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Leaves valid high; the caller lowers it after the last register of a batch.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_coefs(input logic [31:0] hb0, input logic [31:0] ha1,
                              input logic [31:0] ha2, input logic [31:0] lb0,
                              input logic [31:0] la1, input logic [31:0] la2);
        write_reg(CFG_HP_GAIN, hb0);
        write_reg(CFG_HP_POLE_ONE, ha1);
        write_reg(CFG_HP_POLE_TWO, ha2);
        write_reg(CFG_LP_GAIN, lb0);
        write_reg(CFG_LP_POLE_ONE, la1);
        write_reg(CFG_LP_POLE_TWO, la2);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_bypass(input logic on);
        logic [CFG_DATA_W-1:0] data;
        // Upper bits carry junk; only bit zero counts.
        data = $urandom;
        data[0] = on;
        write_reg(CFG_BYPASS, data);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] to_q30(input real v);
        return $rtoi(v * 1073741824.0);
    endfunction

    // Second-order Butterworth sections, cutoffs given as a fraction of the sample rate.
    task automatic design_band(input real f_hp, input real f_lp);
        real c_hp, c_lp, al_hp, al_lp, n_hp, n_lp;
        c_hp  = $cos(TWO_PI * f_hp);
        al_hp = $sin(TWO_PI * f_hp) / (2.0 * BUTTERWORTH_Q);
        n_hp  = 1.0 + al_hp;
        c_lp  = $cos(TWO_PI * f_lp);
        al_lp = $sin(TWO_PI * f_lp) / (2.0 * BUTTERWORTH_Q);
        n_lp  = 1.0 + al_lp;
        load_coefs(to_q30((1.0 + c_hp) / (2.0 * n_hp)), to_q30(-2.0 * c_hp / n_hp),
                   to_q30((1.0 - al_hp) / n_hp), to_q30((1.0 - c_lp) / (2.0 * n_lp)),
                   to_q30(-2.0 * c_lp / n_lp), to_q30((1.0 - al_lp) / n_lp));
    endtask

    task automatic wait_drain();
        while (results_seen != items_sent) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    // Runs of tones, noisy tones, noise, near-silence and full-scale squares.
    task automatic play_random(input int n_items);
        int    left, run, k, amp, period, t;
        real   phase, step;
        t_wave wave;
        logic signed [SAMPLE_W-1:0] v;
        left = n_items;
        while (left > 0) begin
            run = $urandom_range(16, 96);
            if (run > left) run = left;
            k = $urandom_range(0, 9);
            wave = (k < 4) ? WAVE_TONE : (k < 6) ? WAVE_NOISY_TONE :
                   (k < 7) ? WAVE_NOISE : (k < 8) ? WAVE_QUIET : WAVE_SQUARE;
            amp = $urandom_range(1, 32767);
            step = TWO_PI * $urandom_range(1, 2000) / 4000.0;
            period = $urandom_range(1, 16);
            phase = TWO_PI * $urandom_range(0, 999) / 1000.0;
            for (k = 0; k < run; k++) begin
                case (wave)
                    WAVE_TONE: t = $rtoi(amp * $sin(phase));
                    WAVE_NOISY_TONE: t = $rtoi(amp * $sin(phase))
                                         + int'($urandom_range(0, 1023)) - 512;
                    WAVE_NOISE: t = int'($signed(16'($urandom)));
                    WAVE_QUIET: t = int'($urandom_range(0, 255)) - 128;
                    default: t = ((k / period) % 2) ? 32767 : -32768;
                endcase
                if (t > 32767) t = 32767;
                if (t < -32768) t = -32768;
                v = t[SAMPLE_W-1:0];
                phase += step;
                send_sample(v);
            end
            left -= run;
        end
    endtask

    task automatic apply_setting(input t_setting sel);
        case (sel)
            SET_BAND_LOW:    design_band(0.01, 0.15);
            SET_BAND_WIDE:   design_band(0.002, 0.45);
            SET_BAND_NARROW: design_band(0.05, 0.1);
            SET_ALL_MAX:     load_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            SET_ALL_MIN:     load_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            SET_RANDOM:      load_coefs($urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom);
            SET_BYPASS:      set_bypass(1'b1);
            default: begin
                set_bypass(1'b0);
                @(posedge i_clk);
                design_band($urandom_range(2, 100) / 1000.0, $urandom_range(50, 450) / 1000.0);
            end
        endcase
    endtask

    initial begin
        int k;
        int p;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Coefficients still at their reset value: everything filters to zero.
        for (k = 0; k < 5; k++) send_sample(corner_vals[k]);
        i_in_valid <= 1'b0;
        wait_drain();

        // Full-scale steps and a full-scale alternation through a real band-pass.
        design_band(0.01, 0.2);
        for (k = 0; k < 3; k++) send_sample(16'sh7FFF);
        for (k = 0; k < 3; k++) send_sample(16'sh8000);
        for (k = 0; k < 4; k++) send_sample((k % 2) ? 16'sh8000 : 16'sh7FFF);
        send_sample(16'sh0000);
        i_in_valid <= 1'b0;
        wait_drain();

        // Bypass must pass samples untouched and leave the delay line alone.
        set_bypass(1'b1);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        i_in_valid <= 1'b0;
        wait_drain();
        set_bypass(1'b0);
        @(posedge i_clk);
        // A write to the unused index must change nothing.
        write_reg(CFG_SPARE, $urandom);
        i_cfg_valid <= 1'b0;
        send_sample(16'sh1234);
        i_in_valid <= 1'b0;
        wait_drain();

        // Largest coefficients saturate every stage.
        apply_setting(SET_ALL_MAX);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        i_in_valid <= 1'b0;
        wait_drain();

        for (p = SET_BAND_LOW; p <= SET_BAND_RANDOM; p++) begin
            apply_setting(t_setting'(p));
            gaps_on = (p != SET_BAND_NARROW);
            if (p == SET_BAND_WIDE) holds_asked <= holds_asked + 1;
            play_random((p == SET_BYPASS) ? BYPASS_ITEMS : PHASE_ITEMS);
            i_in_valid <= 1'b0;
            wait_drain();
        end

        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
